// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro expands to a labeled
// concurrent assertion in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("assertion failed");
// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clock, reset, cond) \
  label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clock, reset, prop)
`define ASSERT_NEVER(label, clock, reset, cond)
`endif
`endif

// ----- rtl/mbpp_pkg.sv -----
package mbpp_pkg;

  // Macroblock mode codes.
  localparam logic [1:0] MODE_INTRA = 2'd0;
  localparam logic [1:0] MODE_FWD   = 2'd1;
  localparam logic [1:0] MODE_TWO   = 2'd2;
  localparam logic [1:0] MODE_BIDIR = 2'd3;

  // Default depth of the queue between the classifier and the serializer.
  localparam int QUEUE_DEPTH = 2;

  // One classified request: up to four code bytes, byte 0 in bits 7:0,
  // and the index of the final byte.
  typedef struct packed {
    logic [31:0] bytes;
    logic [1:0]  last_idx;
  } pkt_t;

  // Read side of the queue as seen by the serializer.
  typedef struct packed {
    logic valid;
    logic full;
  } qstat_t;

  // True when a 7-bit two's complement value lies in -4..3.
  function automatic logic fits3(input logic [6:0] v);
    return (v[6:2] == 5'b00000) || (v[6:2] == 5'b11111);
  endfunction

endpackage

// ----- rtl/macroblock_param_packer_core.sv -----
// Macroblock parameter packer.
// Input channel: drive push with mode, intra_submode and the four motion
// components; a request is taken at a rising edge where push is high and
// full is low. Output channel: while empty is low, code_byte and last_byte
// show the oldest waiting byte; it is taken at an edge where pop is high.
// last_byte marks the final byte of each macroblock's code.
// Each request yields 1, 2 or 4 bytes. A taken request is first written into
// the queue; the serializer then loads its first byte into the output
// register, and bytes follow one per cycle while pop takes them. The
// serializer sets the sustained rate of requests.
// Classified requests wait in a queue of QueueDepth entries; input is taken
// every cycle while the queue has room, even while output is stalled.
// If pop stays low, bytes hold and the queue fills, after which full rises.
// Reset (synchronous, active high) empties the queue and the output stage.
`include "assert_macros.svh"

module macroblock_param_packer_core #(
  parameter int QueueDepth = mbpp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        mode,
  input  logic [5:0]        intra_submode,
  input  logic signed [6:0] motion_x,
  input  logic signed [6:0] motion_y,
  input  logic signed [6:0] motion_x_second,
  input  logic signed [6:0] motion_y_second,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        code_byte,
  output logic              last_byte
);

  mbpp_pkg::pkt_t   front_pkt;
  mbpp_pkg::pkt_t   head_pkt;
  mbpp_pkg::qstat_t qstat;
  logic             q_pop;
  logic [1:0]       byte_idx;

  assign full = qstat.full;

  // Classify and pack the incoming request.
  mbpp_front u_front (
    .mode            (mode),
    .intra_submode   (intra_submode),
    .motion_x        (motion_x),
    .motion_y        (motion_y),
    .motion_x_second (motion_x_second),
    .motion_y_second (motion_y_second),
    .pkt             (front_pkt)
  );

  // Decoupling queue.
  mbpp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_pkt (front_pkt),
    .rd_en  (q_pop),
    .rd_pkt (head_pkt),
    .stat   (qstat)
  );

  // Byte serializer with output register.
  mbpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head_pkt),
    .q_pop     (q_pop),
    .byte_idx  (byte_idx),
    .pop       (pop),
    .empty     (empty),
    .code_byte (code_byte),
    .last_byte (last_byte)
  );

  // A byte that is not the last of its code is always followed directly.
  `ASSERT_CLK(a_code_continues, clk, rst, (pop && !empty && !last_byte) |=> !empty)
  // With nothing queued, the serializer must be at the start of a request.
  `ASSERT_NEVER(a_idx_idle, clk, rst, !qstat.valid && (byte_idx != 2'd0))
  // The queue only releases a request while holding one.
  `ASSERT_NEVER(a_pop_nonempty, clk, rst, q_pop && !qstat.valid)

endmodule

// ----- rtl/mbpp_front.sv -----
module mbpp_front (
  input  logic [1:0]        mode,
  input  logic [5:0]        intra_submode,
  input  logic signed [6:0] motion_x,
  input  logic signed [6:0] motion_y,
  input  logic signed [6:0] motion_x_second,
  input  logic signed [6:0] motion_y_second,
  output mbpp_pkg::pkt_t    pkt
);

  logic [6:0] x, y, u, v;
  logic       short1, short2, bidir;

  assign x = motion_x;
  assign y = motion_y;
  assign u = motion_x_second;
  assign v = motion_y_second;

  // Classify the vectors by whether they fit the short 3-bit form.
  assign short1 = mbpp_pkg::fits3(x) && mbpp_pkg::fits3(y);
  assign short2 = short1 && mbpp_pkg::fits3(u) && mbpp_pkg::fits3(v);
  assign bidir  = (mode == mbpp_pkg::MODE_BIDIR);

  // Assemble the code bytes for the selected layout.
  always_comb begin
    pkt = '0;
    unique case (mode)
      mbpp_pkg::MODE_INTRA: begin
        pkt.bytes[7:0] = {2'b00, intra_submode};
        pkt.last_idx   = 2'd0;
      end
      mbpp_pkg::MODE_FWD: begin
        if (short1) begin
          pkt.bytes[7:0] = {2'b10, x[2:0], y[2:0]};
          pkt.last_idx   = 2'd0;
        end else begin
          pkt.bytes[7:0]  = {2'b11, x[6:1]};
          pkt.bytes[15:8] = {x[0], y[6:0]};
          pkt.last_idx    = 2'd1;
        end
      end
      default: begin
        if (short2) begin
          pkt.bytes[7:0]  = {2'b01, bidir, 1'b0, x[2:0], y[2]};
          pkt.bytes[15:8] = {y[1:0], u[2:0], v[2:0]};
          pkt.last_idx    = 2'd1;
        end else begin
          pkt.bytes[7:0]   = {2'b01, bidir, 1'b1, x[6:3]};
          pkt.bytes[15:8]  = {x[2:0], y[6:2]};
          pkt.bytes[23:16] = {y[1:0], u[6:1]};
          pkt.bytes[31:24] = {u[0], v[6:0]};
          pkt.last_idx     = 2'd3;
        end
      end
    endcase
  end

endmodule

// ----- rtl/mbpp_queue.sv -----
module mbpp_queue #(
  parameter int Depth = mbpp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  mbpp_pkg::pkt_t    wr_pkt,
  input  logic              rd_en,
  output mbpp_pkg::pkt_t    rd_pkt,
  output mbpp_pkg::qstat_t  stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mbpp_pkg::pkt_t         slots [Depth];
  logic [PtrW-1:0]        wr_ptr, rd_ptr;
  logic [CntW-1:0]        count;
  logic                   do_push, do_pop;

  assign stat.valid = (count != '0);
  assign stat.full  = (count == CntW'(Depth));
  assign do_push    = wr_en && !stat.full;
  assign do_pop     = rd_en && stat.valid;
  assign rd_pkt     = slots[rd_ptr];

  // Storage for waiting requests.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_pkt;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/mbpp_back.sv -----
module mbpp_back (
  input  logic             clk,
  input  logic             rst,
  input  mbpp_pkg::qstat_t qstat,
  input  mbpp_pkg::pkt_t   head,
  output logic             q_pop,
  output logic [1:0]       byte_idx,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       code_byte,
  output logic             last_byte
);

  logic out_valid;
  logic load;
  logic at_last;

  assign empty   = !out_valid;
  assign load    = qstat.valid && (!out_valid || pop);
  assign at_last = (byte_idx == head.last_idx);
  assign q_pop   = load && at_last;

  // Output register handshake and byte position within the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        byte_idx  <= at_last ? 2'd0 : byte_idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      code_byte <= head.bytes[byte_idx*8 +: 8];
      last_byte <= at_last;
    end
  end

endmodule
